### rtl/kcb_pkg.sv
// Shared types, constants and the base32 alphabet function of the key checksum encoder.
package kcb_pkg;

    // Input word: one key byte and the version byte sampled with the first byte.
    typedef struct packed {
        logic [7:0] key_byte;
        logic [7:0] version;
    } t_in_word;

    // Output word: one base32 character and the end-of-key mark.
    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
    } t_out_word;

    // Byte token passed from the front to the back through the queue.
    typedef struct packed {
        logic [7:0] data;
        logic       start_item;  // First token produced by an input word.
        logic       key_start;   // Version byte, which opens a new key.
        logic       key_last;    // Token belongs to the last input word of a key.
        logic       fin;         // High checksum byte, which closes the key.
    } t_token;

    // Token queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // CRC-16/XMODEM polynomial.
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Characters for the last input word of a key before the rest is dropped.
    localparam logic [2:0] MAX_CHARS = 3'd5;

    // Base32 alphabet anchors.
    localparam logic [6:0] ASCII_A    = 7'd65;
    localparam logic [6:0] ASCII_2    = 7'd50;
    localparam logic [4:0] DIGIT_BASE = 5'd26;

    // Map a 5-bit group onto the A-Z2-7 alphabet.
    function automatic logic [6:0] b32_char(input logic [4:0] idx);
        logic [6:0] code;
        if (idx < DIGIT_BASE) begin
            code = ASCII_A + {2'b00, idx};
        end else begin
            code = ASCII_2 + {2'b00, idx - DIGIT_BASE};
        end
        return code;
    endfunction

endpackage

### rtl/kcb_front.sv
// Front end: accepts key bytes, runs the checksum and issues byte tokens to the queue.
module kcb_front
    import kcb_pkg::*;
#(
    parameter int KEY_BYTES = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_word i_in_word,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_token   o_q_data
);

    localparam int CW = $clog2(KEY_BYTES + 1);

    localparam logic [1:0] PH_VER = 2'd0;
    localparam logic [1:0] PH_KB  = 2'd1;
    localparam logic [1:0] PH_LO  = 2'd2;
    localparam logic [1:0] PH_HI  = 2'd3;

    // One byte through the CRC-16/XMODEM shift register.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    logic          r_full;
    logic [1:0]    r_phase;
    logic [7:0]    r_kb;
    logic [7:0]    r_ver;
    logic          r_lastk;
    logic          r_startpend;
    logic [CW-1:0] r_bcnt;
    logic [15:0]   r_crc;

    logic          accept;
    logic          push;
    logic          final_ph;
    logic [7:0]    tok_byte;
    logic [15:0]   crc_in;
    logic [15:0]   n_crc;
    logic          bcnt_last;

    // Pick the byte for the current phase of the held word.
    always_comb begin
        case (r_phase)
            PH_VER:  tok_byte = r_ver;
            PH_KB:   tok_byte = r_kb;
            PH_LO:   tok_byte = r_crc[7:0];
            PH_HI:   tok_byte = r_crc[15:8];
            default: tok_byte = r_kb;
        endcase
    end

    // The checksum restarts at the version byte and does not cover its own bytes.
    assign crc_in = (r_phase == PH_VER) ? 16'h0000 : r_crc;
    assign n_crc  = (r_phase == PH_VER || r_phase == PH_KB) ? crc_feed(crc_in, tok_byte)
                                                            : r_crc;

    assign push       = r_full && !i_q_full;
    assign final_ph   = (r_phase == PH_KB && !r_lastk) || (r_phase == PH_HI);
    assign o_in_stall = r_full && !(push && final_ph);
    assign accept     = i_in_valid && !o_in_stall;
    assign bcnt_last  = (r_bcnt == CW'(KEY_BYTES - 1));

    // Token toward the back end.
    assign o_q_push             = push;
    assign o_q_data.data        = tok_byte;
    assign o_q_data.start_item  = r_startpend;
    assign o_q_data.key_start   = (r_phase == PH_VER);
    assign o_q_data.key_last    = r_lastk;
    assign o_q_data.fin         = (r_phase == PH_HI);

    // Control state: holding flag, phase and position within the key.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full      <= 1'b0;
            r_phase     <= PH_VER;
            r_lastk     <= 1'b0;
            r_startpend <= 1'b0;
            r_bcnt      <= '0;
            r_crc       <= 16'h0000;
        end else begin
            if (push) begin
                r_crc <= n_crc;
                if (!final_ph) begin
                    r_phase <= r_phase + 2'd1;
                end
            end
            if (accept) begin
                r_full      <= 1'b1;
                r_startpend <= 1'b1;
                r_phase     <= (r_bcnt == '0) ? PH_VER : PH_KB;
                r_lastk     <= bcnt_last;
                r_bcnt      <= bcnt_last ? '0 : r_bcnt + CW'(1);
            end else if (push) begin
                r_startpend <= 1'b0;
                if (final_ph) begin
                    r_full <= 1'b0;
                end
            end
        end
    end

    // Held payload of the accepted word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kb  <= i_in_word.key_byte;
            r_ver <= i_in_word.version;
        end
    end

endmodule

### rtl/kcb_queue.sv
// Short token queue that decouples the front end from the character back end.
module kcb_queue
    import kcb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_push_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_token o_pop_data
);

    t_token            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;

    assign o_full     = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_pop_data = r_mem[r_rptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

    // Token storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

### rtl/kcb_back.sv
// Back end: packs tokens in 5-bit groups; one base32 character per cycle unless stalled.
module kcb_back
    import kcb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_token    i_q_data,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic [11:0] r_acc;
    logic [3:0]  r_cnt;
    logic        r_fin;
    logic        r_klast;
    logic [2:0]  r_nch;
    logic        r_drop;
    logic        r_ovalid;
    t_out_word   r_out;

    logic        have_cur;
    logic        adv;
    logic        discard;
    logic        emit;
    logic [11:0] src_acc;
    logic [3:0]  src_cnt;
    logic        src_fin;
    logic        src_klast;
    logic [2:0]  src_nch;
    logic [3:0]  base_cnt;
    logic [3:0]  base_bits;
    logic [11:0] shifted;
    logic [4:0]  idx;
    logic [3:0]  n_cnt;
    logic [11:0] n_acc;
    logic [2:0]  n_nch;
    logic        last;

    // A character is pending in the current token, or the queue must supply one.
    assign have_cur = (r_cnt >= 4'd5) || (r_fin && r_cnt != 4'd0);
    assign adv      = !r_ovalid || !i_out_stall;
    assign discard  = r_drop && !i_q_data.start_item;
    assign o_q_pop  = i_q_valid && !have_cur && (adv || discard);
    assign emit     = adv && (have_cur || (i_q_valid && !discard));

    // Source of the next character: leftover bits or a freshly popped byte.
    always_comb begin
        base_cnt  = i_q_data.key_start ? 4'd0 : r_cnt;
        base_bits = i_q_data.key_start ? 4'd0 : r_acc[3:0];
        if (have_cur) begin
            src_acc   = r_acc;
            src_cnt   = r_cnt;
            src_fin   = r_fin;
            src_klast = r_klast;
            src_nch   = r_nch;
        end else begin
            src_acc   = {base_bits, i_q_data.data};
            src_cnt   = base_cnt + 4'd8;
            src_fin   = i_q_data.fin;
            src_klast = i_q_data.key_last;
            src_nch   = i_q_data.start_item ? 3'd0 : r_nch;
        end
    end

    // Cut the top group, or pad the final partial group with zeros.
    always_comb begin
        if (src_cnt >= 4'd5) begin
            shifted = src_acc >> (src_cnt - 4'd5);
            n_cnt   = src_cnt - 4'd5;
        end else begin
            shifted = src_acc << (4'd5 - src_cnt);
            n_cnt   = 4'd0;
        end
        idx   = shifted[4:0];
        n_acc = src_acc & ((12'd1 << n_cnt) - 12'd1);
        n_nch = src_nch + 3'd1;
        last  = (src_fin && n_cnt == 4'd0) || (src_klast && n_nch == MAX_CHARS);
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

    // Packing state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= 12'd0;
            r_cnt    <= 4'd0;
            r_fin    <= 1'b0;
            r_klast  <= 1'b0;
            r_nch    <= 3'd0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
                r_nch    <= n_nch;
                r_klast  <= src_klast;
                // After the final character the rest of the word's tokens are skipped.
                r_drop   <= last && !src_fin;
                if (last) begin
                    r_acc <= 12'd0;
                    r_cnt <= 4'd0;
                    r_fin <= 1'b0;
                end else begin
                    r_acc <= n_acc;
                    r_cnt <= n_cnt;
                    r_fin <= src_fin;
                end
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.char_code <= b32_char(idx);
            r_out.last_char <= last;
        end
    end

endmodule

### rtl/key_checksum_base32_encoder.sv
// Top level of the key checksum base32 encoder: front end, token queue and back end.
//
// Usage: the input channel takes one key byte per word, first byte first, KEY_BYTES
// words per key; the version field is sampled only with the first byte of a key.
// The output channel gives one ASCII base32 character (A-Z, 2-7) per word, covering
// the version byte, the key bytes and the CRC-16/XMODEM checksum (low byte first),
// most significant bits first; the final character of a key carries last_char.
// Path: the first character of a word passes the front register, the token queue
// and the output register before it is valid, and waits longer while earlier
// characters are still draining.
// Throughput: the back end sends one character per cycle unless the receiver stalls,
// so a key of 32 bytes gives 56 characters; while the queue has room the front end
// issues a byte token per cycle, two for a key's first word and three for its last.
// Reset clears the key position, the checksum and all queued work; payload
// registers are not reset. When the receiver stalls, the output word holds, the
// queue fills and then the input channel stalls; no character is lost.
module key_checksum_base32_encoder
    import kcb_pkg::*;
#(
    parameter int KEY_BYTES = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    t_token q_in;
    t_token q_out;

    // Front end: checksum and byte tokens.
    kcb_front #(
        .KEY_BYTES(KEY_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_word (i_in_word),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_data  (q_in)
    );

    // Token queue between the two halves.
    kcb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_data(q_in),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_pop_data (q_out)
    );

    // Back end: base32 packing and output register.
    kcb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_out),
        .o_q_pop    (q_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

endmodule
